>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SNI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SNI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sni_pkg.sv
// ----------------------------------------------------------------------------
// sni_pkg
// types and constants of the tls client hello server-name extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sni_pkg;

  // default sizes
  localparam int CAPTURE_BYTES_DEF  = 255;
  localparam int MAX_EXTENSIONS_DEF = 10;
  localparam int NAME_BUFFER_DEF    = 64;

  // record and handshake bytes
  localparam logic [7:0] TLS_HANDSHAKE    = 8'h16;
  localparam logic [7:0] TLS_MAJOR        = 8'h03;
  localparam logic [7:0] TLS_CLIENT_HELLO = 8'h01;

  // fixed layout positions
  localparam int HELLO_TYPE_AT = 5;
  localparam int SESSION_ID_AT = 43;
  localparam int MIN_HELLO     = 47;

  // status codes
  localparam logic [1:0] ST_NAME_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_HELLO  = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;
  localparam logic [1:0] ST_NO_NAME    = 2'd3;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_SESS,
    PH_CIPH,
    PH_COMP,
    PH_EXTLEN,
    PH_EXTHDR,
    PH_SNILIST,
    PH_SNIENT,
    PH_NAME,
    PH_DONE
  } sni_phase_t;

  // one input request
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [15:0] message_length;
    logic        first_byte;
    logic        last_byte;
  } sni_item_t;

  // one result request
  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       name_last;
    logic       message_done;
    logic [1:0] status;
  } sni_result_t;

endpackage

>>> hw/rtl/sni_in_if.sv
// ----------------------------------------------------------------------------
// sni_in_if
// byte channel into the extractor: valid, ready and one payload byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sni_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [15:0] message_length;
  logic        first_byte;
  logic        last_byte;

  modport source (output valid, byte_value, message_length, first_byte, last_byte,
                  input ready);
  modport sink   (input valid, byte_value, message_length, first_byte, last_byte,
                  output ready);
endinterface

>>> hw/rtl/sni_out_if.sv
// ----------------------------------------------------------------------------
// sni_out_if
// result channel out of the extractor: name bytes and end-of-send status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sni_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       char_valid;
  logic       name_last;
  logic       message_done;
  logic [1:0] status;

  modport source (output valid, name_char, char_valid, name_last, message_done, status,
                  input ready);
  modport sink   (input valid, name_char, char_valid, name_last, message_done, status,
                  output ready);
endinterface

>>> hw/rtl/sni_in_stage.sv
// ----------------------------------------------------------------------------
// sni_in_stage
// input register: holds one accepted byte request until the parser takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sni_in_stage
  import sni_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sni_in_if.sink    byte_stream,
  input  logic      out_free,
  output logic      item_valid,
  output sni_item_t item
);

  logic take;

  // room when empty or when the held request moves on this cycle
  assign byte_stream.ready = !item_valid || out_free;
  assign take = byte_stream.valid && byte_stream.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (out_free) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item.byte_value     <= byte_stream.byte_value;
      item.message_length <= byte_stream.message_length;
      item.first_byte     <= byte_stream.first_byte;
      item.last_byte      <= byte_stream.last_byte;
    end
  end

endmodule

>>> hw/rtl/sni_parse.sv
// ----------------------------------------------------------------------------
// sni_parse
// client hello walker: while step is high, one byte per cycle updates the parser registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sni_parse
  import sni_pkg::*;
#(
  parameter int CAPTURE_BYTES  = CAPTURE_BYTES_DEF,
  parameter int MAX_EXTENSIONS = MAX_EXTENSIONS_DEF,
  parameter int NAME_BUFFER    = NAME_BUFFER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  sni_item_t   item,
  output logic        res_valid,
  output sni_result_t res
);

  localparam int POS_W = $clog2(CAPTURE_BYTES + 1);
  localparam int CW    = ((POS_W > 16) ? POS_W : 16) + 2;
  localparam int CNT_W = $clog2(MAX_EXTENSIONS + 1);
  localparam logic [7:0] NAME_CAP = 8'(NAME_BUFFER - 1);

  // parser registers
  sni_phase_t        phase, phase_mid, phase_next, ph;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  cap_len, cap_next;
  logic [POS_W-1:0]  off, off_next;
  logic [POS_W-1:0]  ext_limit, limit_next;
  logic [CNT_W-1:0]  ext_count, count_next;
  logic [7:0]        hb, hb_next;
  logic [15:0]       ll, ll_next;
  logic [7:0]        nbl, nbl_next;
  logic [1:0]        outcome, outcome_next;

  // working values
  logic [7:0]        b;
  logic [15:0]       v;
  logic [POS_W-1:0]  p, k;
  logic [CW-1:0]     at, lim;
  logic              sni_hit;
  logic              emit_char, emit_last, done;

  assign b = item.byte_value;

  // next state
  always_comb begin
    pos_next     = pos;
    cap_next     = cap_len;
    off_next     = off;
    limit_next   = ext_limit;
    count_next   = ext_count;
    hb_next      = hb;
    ll_next      = ll;
    nbl_next     = nbl;
    outcome_next = outcome;
    phase_mid    = phase;
    emit_char    = 1'b0;
    emit_last    = 1'b0;
    at           = '0;
    lim          = '0;
    sni_hit      = 1'b0;

    // new send restarts everything
    if (item.first_byte) begin
      pos_next     = '0;
      off_next     = '0;
      limit_next   = '0;
      count_next   = '0;
      hb_next      = '0;
      ll_next      = '0;
      nbl_next     = '0;
      outcome_next = ST_NAME_FOUND;
      cap_next     = (item.message_length > 16'(CAPTURE_BYTES)) ?
                     POS_W'(CAPTURE_BYTES) : item.message_length[POS_W-1:0];
      if (item.message_length < 16'(MIN_HELLO)) begin
        phase_mid    = PH_DONE;
        outcome_next = ST_NOT_HELLO;
      end else begin
        phase_mid = PH_HDR;
      end
    end

    ph = phase_mid;
    p  = pos_next;
    k  = pos_next - off_next;
    v  = {hb_next, b};

    // byte inside the captured prefix
    if (ph != PH_IDLE && pos_next < cap_next) begin
      if (ph == PH_HDR) begin
        if ((p == '0 && b != TLS_HANDSHAKE) || (p == POS_W'(1) && b != TLS_MAJOR) ||
            (p == POS_W'(HELLO_TYPE_AT) && b != TLS_CLIENT_HELLO)) begin
          phase_mid    = PH_DONE;
          outcome_next = ST_NOT_HELLO;
        end else if (p == POS_W'(SESSION_ID_AT - 1)) begin
          if (CW'(SESSION_ID_AT + 1) > CW'(cap_next)) begin
            phase_mid    = PH_DONE;
            outcome_next = ST_MALFORMED;
          end else begin
            phase_mid = PH_SESS;
            off_next  = POS_W'(SESSION_ID_AT);
          end
        end
      end else if (ph != PH_DONE && p >= off_next) begin
        unique case (ph)
          // session id length
          PH_SESS: begin
            at = CW'(off_next) + CW'(b) + CW'(1);
            if (at + CW'(2) > CW'(cap_next)) begin
              phase_mid    = PH_DONE;
              outcome_next = ST_MALFORMED;
            end else begin
              phase_mid = PH_CIPH;
              off_next  = at[POS_W-1:0];
            end
          end
          // cipher suites length
          PH_CIPH: begin
            if (k == '0) begin
              hb_next = b;
            end else begin
              at = CW'(off_next) + CW'(v) + CW'(2);
              if (at + CW'(1) > CW'(cap_next)) begin
                phase_mid    = PH_DONE;
                outcome_next = ST_MALFORMED;
              end else begin
                phase_mid = PH_COMP;
                off_next  = at[POS_W-1:0];
              end
            end
          end
          // compression methods length
          PH_COMP: begin
            at = CW'(off_next) + CW'(b) + CW'(1);
            if (at + CW'(2) > CW'(cap_next)) begin
              phase_mid    = PH_DONE;
              outcome_next = ST_MALFORMED;
            end else begin
              phase_mid = PH_EXTLEN;
              off_next  = at[POS_W-1:0];
            end
          end
          // extension block length, clipped to the prefix
          PH_EXTLEN: begin
            if (k == '0) begin
              hb_next = b;
            end else begin
              lim        = CW'(off_next) + CW'(v) + CW'(2);
              limit_next = (lim > CW'(cap_next)) ? cap_next : lim[POS_W-1:0];
              count_next = '0;
              at         = CW'(off_next) + CW'(2);
              if (at + CW'(4) > CW'(limit_next)) begin
                phase_mid    = PH_DONE;
                outcome_next = ST_NO_NAME;
              end else begin
                phase_mid = PH_EXTHDR;
                off_next  = at[POS_W-1:0];
              end
            end
          end
          // extension type and length
          PH_EXTHDR: begin
            if (k == '0 || k == POS_W'(2)) begin
              hb_next = b;
            end else if (k == POS_W'(1)) begin
              ll_next = v;
            end else begin
              sni_hit    = (ll == '0);
              ll_next    = v;
              count_next = ext_count + CNT_W'(1);
              if (sni_hit) begin
                at = CW'(off_next) + CW'(4);
                if (at + CW'(2) > CW'(limit_next)) begin
                  phase_mid    = PH_DONE;
                  outcome_next = ST_MALFORMED;
                end else begin
                  phase_mid = PH_SNILIST;
                  off_next  = at[POS_W-1:0];
                end
              end else begin
                at = CW'(off_next) + CW'(v) + CW'(4);
                if (count_next >= CNT_W'(MAX_EXTENSIONS) ||
                    at + CW'(4) > CW'(limit_next)) begin
                  phase_mid    = PH_DONE;
                  outcome_next = ST_NO_NAME;
                end else begin
                  phase_mid = PH_EXTHDR;
                  off_next  = at[POS_W-1:0];
                end
              end
            end
          end
          // server-name list length
          PH_SNILIST: begin
            if (k == POS_W'(1)) begin
              at = CW'(off_next) + CW'(2);
              if (at + CW'(3) > CW'(limit_next)) begin
                phase_mid    = PH_DONE;
                outcome_next = ST_MALFORMED;
              end else begin
                phase_mid = PH_SNIENT;
                off_next  = at[POS_W-1:0];
              end
            end
          end
          // entry type and name length
          PH_SNIENT: begin
            if (k == '0) begin
              nbl_next = b;
            end else if (k == POS_W'(1)) begin
              hb_next = b;
            end else begin
              at = CW'(off_next) + CW'(v) + CW'(3);
              if (nbl == '0 && at <= CW'(limit_next)) begin
                nbl_next = (v > 16'(NAME_CAP)) ? NAME_CAP : v[7:0];
                if (nbl_next == '0) begin
                  phase_mid    = PH_DONE;
                  outcome_next = ST_NAME_FOUND;
                end else begin
                  phase_mid = PH_NAME;
                  off_next  = off_next + POS_W'(3);
                end
              end else begin
                // unusable entry: resume after the extension body
                at = CW'(off_next) - CW'(2) + CW'(ll);
                if (at <= CW'(p)) begin
                  phase_mid    = PH_DONE;
                  outcome_next = ST_MALFORMED;
                end else if (ext_count >= CNT_W'(MAX_EXTENSIONS) ||
                             at + CW'(4) > CW'(limit_next)) begin
                  phase_mid    = PH_DONE;
                  outcome_next = ST_NO_NAME;
                end else begin
                  phase_mid = PH_EXTHDR;
                  off_next  = at[POS_W-1:0];
                end
              end
            end
          end
          // name bytes stream out
          PH_NAME: begin
            emit_char = 1'b1;
            nbl_next  = nbl - 8'd1;
            if (nbl_next == '0) begin
              emit_last    = 1'b1;
              phase_mid    = PH_DONE;
              outcome_next = ST_NAME_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      pos_next = pos_next + POS_W'(1);
    end

    // end of send closes the parse
    done       = item.last_byte && (phase_mid != PH_IDLE);
    phase_next = done ? PH_IDLE : phase_mid;
  end

  // result
  always_comb begin
    res              = '0;
    res.char_valid   = emit_char;
    res.name_char    = emit_char ? b : 8'd0;
    res.name_last    = emit_last;
    res.message_done = done;
    if (done) begin
      if (phase_mid == PH_DONE) begin
        res.status = outcome_next;
      end else if (phase_mid == PH_HDR && pos_next <= POS_W'(HELLO_TYPE_AT)) begin
        res.status = ST_NOT_HELLO;
      end else begin
        res.status = ST_MALFORMED;
      end
    end
    res_valid = step && (emit_char || done);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pos       <= '0;
      cap_len   <= '0;
      off       <= '0;
      ext_limit <= '0;
      ext_count <= '0;
      hb        <= '0;
      ll        <= '0;
      nbl       <= '0;
      outcome   <= ST_NAME_FOUND;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      cap_len   <= cap_next;
      off       <= off_next;
      ext_limit <= limit_next;
      ext_count <= count_next;
      hb        <= hb_next;
      ll        <= ll_next;
      nbl       <= nbl_next;
      outcome   <= outcome_next;
    end
  end

endmodule

>>> hw/rtl/sni_out_stage.sv
// ----------------------------------------------------------------------------
// sni_out_stage
// result register: holds one result request until the consumer takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sni_out_stage
  import sni_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  sni_result_t res,
  output logic        out_free,
  sni_out_if.source   result_stream
);

  sni_result_t held;

  assign out_free = !result_stream.valid || result_stream.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_stream.valid <= 1'b0;
    end else if (load) begin
      result_stream.valid <= 1'b1;
    end else if (result_stream.ready) begin
      result_stream.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result_stream.name_char    = held.name_char;
  assign result_stream.char_valid   = held.char_valid;
  assign result_stream.name_last    = held.name_last;
  assign result_stream.message_done = held.message_done;
  assign result_stream.status       = held.status;

endmodule

>>> hw/rtl/tls_client_hello_sni_extract_top.sv
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extract_top
// path: an accepted byte is held in the input register, and its result is loaded into the result register
// throughput: one byte per cycle while the result side has room
// backpressure: a stalled result holds; the input register takes one more byte
// and then input ready stays low until the result is taken
// reset: synchronous rst returns the parser to idle and empties both registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_client_hello_sni_extract_top
  import sni_pkg::*;
#(
  parameter int CAPTURE_BYTES  = CAPTURE_BYTES_DEF,
  parameter int MAX_EXTENSIONS = MAX_EXTENSIONS_DEF,
  parameter int NAME_BUFFER    = NAME_BUFFER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sni_in_if.sink    byte_stream,
  sni_out_if.source result_stream
);

  logic        out_free;
  logic        item_valid;
  sni_item_t   item;
  logic        step;
  logic        res_valid;
  sni_result_t res;

  // held byte moves into the parser when the result side has room
  assign step = item_valid && out_free;

  sni_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .out_free    (out_free),
    .item_valid  (item_valid),
    .item        (item)
  );

  sni_parse #(
    .CAPTURE_BYTES  (CAPTURE_BYTES),
    .MAX_EXTENSIONS (MAX_EXTENSIONS),
    .NAME_BUFFER    (NAME_BUFFER)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  sni_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .out_free      (out_free),
    .result_stream (result_stream)
  );

endmodule

>>> hw/rtl/sni_checker.sv
// ----------------------------------------------------------------------------
// sni_checker
// port-level checks on the extractor results, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sni_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] name_char,
  input logic       char_valid,
  input logic       name_last,
  input logic       message_done,
  input logic [1:0] status
);

  // every result carries a name byte or a status
  `SNI_ASSERT_IMP(a_result_kind, clk, rst, out_valid, char_valid || message_done, "empty result")

  // status is zero unless the send ended
  `SNI_ASSERT_IMP(a_status_idle, clk, rst, out_valid && !message_done, status == 2'd0, "stray status")

  // end of name only on a name byte, and no byte value without one
  `SNI_ASSERT_IMP(a_name_last, clk, rst, out_valid && (name_last || !char_valid), char_valid ? 1'b1 : (name_char == 8'd0 && !name_last), "bad name flags")

  // a stalled result holds
  `SNI_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(name_char) && $stable(status) && $stable(message_done), "result changed under stall")

endmodule

bind tls_client_hello_sni_extract_top sni_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_stream.valid),
  .out_ready    (result_stream.ready),
  .name_char    (result_stream.name_char),
  .char_valid   (result_stream.char_valid),
  .name_last    (result_stream.name_last),
  .message_done (result_stream.message_done),
  .status       (result_stream.status)
);

>>> tb/tb_tls_client_hello_sni_extract_top.sv
// ----------------------------------------------------------------------------
// tb_tls_client_hello_sni_extract_top
// Streams TLS sends into the server-name extractor one byte per request.
// A scoreboard class holds its own copy of the parser state and predicts
// the name bytes and the end-of-send status. Each result from the block is
// checked against the oldest prediction. The stimulus is mostly ClientHello
// messages with random layouts and names. The rest are sends that end early,
// are padded, short, abandoned, carry a bogus length, or are stray bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tls_client_hello_sni_extract_top;
  import sni_pkg::*;

  // bit-exact model of the parser plus the queue of results still owed
  class sni_scoreboard;
    sni_phase_t  phase;
    logic [7:0]  pos;
    logic [7:0]  cap_len;
    logic [16:0] field_at;
    logic [8:0]  ext_limit;
    logic [3:0]  ext_count;
    logic [7:0]  hi_latch;
    logic [15:0] len_latch;
    logic [7:0]  name_left;
    logic [1:0]  outcome;
    sni_result_t sni_due[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase     = PH_IDLE;
      pos       = '0;
      cap_len   = '0;
      field_at  = '0;
      ext_limit = '0;
      ext_count = '0;
      hi_latch  = '0;
      len_latch = '0;
      name_left = '0;
      outcome   = '0;
    endfunction

    function int outstanding();
      return sni_due.size();
    endfunction

    function void settle(logic [1:0] code);
      phase   = PH_DONE;
      outcome = code;
    endfunction

    // move to a field only if it fits inside the bound
    function void enter(sni_phase_t ph, int at, int need, int bound);
      if (at + need > bound) begin
        settle(ST_MALFORMED);
      end else begin
        phase    = ph;
        field_at = 17'(at);
      end
    endfunction

    function void next_ext(int at);
      if (ext_count >= MAX_EXTENSIONS_DEF || at + 4 > ext_limit) begin
        settle(ST_NO_NAME);
      end else begin
        phase    = PH_EXTHDR;
        field_at = 17'(at);
      end
    endfunction

    // one captured byte through the field walker
    function void parse_byte(logic [7:0] b, inout sni_result_t r);
      int p, off, k, v, lim, target;
      bit is_sni;
      p   = int'(pos);
      off = int'(field_at);
      if (phase == PH_HDR) begin
        if ((p == 0 && b != TLS_HANDSHAKE) || (p == 1 && b != TLS_MAJOR) ||
            (p == HELLO_TYPE_AT && b != TLS_CLIENT_HELLO)) begin
          settle(ST_NOT_HELLO);
        end else if (p + 1 == SESSION_ID_AT) begin
          enter(PH_SESS, SESSION_ID_AT, 1, cap_len);
        end
        return;
      end
      if (p < off) return;
      k = p - off;
      v = int'({hi_latch, b});
      case (phase)
        PH_SESS: enter(PH_CIPH, off + 1 + b, 2, cap_len);
        PH_CIPH: begin
          if (k == 0) hi_latch = b;
          else enter(PH_COMP, off + 2 + v, 1, cap_len);
        end
        PH_COMP: enter(PH_EXTLEN, off + 1 + b, 2, cap_len);
        PH_EXTLEN: begin
          if (k == 0) begin
            hi_latch = b;
          end else begin
            lim       = off + 2 + v;
            ext_limit = 9'((lim > cap_len) ? int'(cap_len) : lim);
            ext_count = '0;
            next_ext(off + 2);
          end
        end
        PH_EXTHDR: begin
          if (k == 0 || k == 2) begin
            hi_latch = b;
          end else if (k == 1) begin
            len_latch = 16'(v);
          end else begin
            is_sni    = (len_latch == 0);
            len_latch = 16'(v);
            ext_count++;
            if (is_sni) enter(PH_SNILIST, off + 4, 2, ext_limit);
            else next_ext(off + 4 + v);
          end
        end
        PH_SNILIST: begin
          if (k == 1) enter(PH_SNIENT, off + 2, 3, ext_limit);
        end
        PH_SNIENT: begin
          if (k == 0) begin
            name_left = b;
          end else if (k == 1) begin
            hi_latch = b;
          end else if (name_left == 0 && off + 3 + v <= ext_limit) begin
            name_left = 8'((v > NAME_BUFFER_DEF - 1) ? NAME_BUFFER_DEF - 1 : v);
            if (name_left == 0) begin
              settle(ST_NAME_FOUND);
            end else begin
              phase    = PH_NAME;
              field_at = 17'(off + 3);
            end
          end else begin
            // unusable entry: step over the whole extension body
            target = off - 2 + len_latch;
            if (target <= p) settle(ST_MALFORMED);
            else next_ext(target);
          end
        end
        PH_NAME: begin
          r.name_char  = b;
          r.char_valid = 1'b1;
          name_left--;
          if (name_left == 0) begin
            r.name_last = 1'b1;
            settle(ST_NAME_FOUND);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(sni_item_t it);
      sni_result_t r;
      r = '0;
      if (it.first_byte) begin
        clear();
        cap_len = 8'((it.message_length > CAPTURE_BYTES_DEF) ? CAPTURE_BYTES_DEF :
                     int'(it.message_length));
        if (it.message_length < MIN_HELLO) settle(ST_NOT_HELLO);
        else phase = PH_HDR;
      end
      if (phase != PH_IDLE && pos < cap_len) begin
        if (phase != PH_DONE) parse_byte(it.byte_value, r);
        pos++;
      end
      if (it.last_byte && phase != PH_IDLE) begin
        if (phase == PH_DONE) r.status = outcome;
        else if (phase == PH_HDR && pos < HELLO_TYPE_AT + 1) r.status = ST_NOT_HELLO;
        else r.status = ST_MALFORMED;
        r.message_done = 1'b1;
        phase = PH_IDLE;
      end
      if (r.char_valid || r.message_done) sni_due.push_back(r);
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] seen);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
      errors++;
    endfunction

    function void check_result(sni_result_t got);
      sni_result_t want;
      if (sni_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = sni_due.pop_front();
      if (got.name_char !== want.name_char) flag("name_char", want.name_char, got.name_char);
      if (got.char_valid !== want.char_valid)
        flag("char_valid", want.char_valid, got.char_valid);
      if (got.name_last !== want.name_last) flag("name_last", want.name_last, got.name_last);
      if (got.message_done !== want.message_done)
        flag("message_done", want.message_done, got.message_done);
      if (got.status !== want.status) flag("status", want.status, got.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;
  bit   hold_armed = 1'b0;
  int   byte_total = 0;
  logic [7:0] hello_q[$];
  sni_scoreboard sb = new();

  sni_in_if  byte_if ();
  sni_out_if result_if ();

  tls_client_hello_sni_extract_top DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_if),
    .result_stream(result_if)
  );

  always #1 clk = ~clk;

  // one byte request, held until the block takes it
  task automatic offer(input logic [7:0] b, input logic [15:0] mlen, input logic first,
                       input logic last);
    sni_item_t it;
    it.byte_value     = b;
    it.message_length = mlen;
    it.first_byte     = first;
    it.last_byte      = last;
    while (!quiet && $urandom_range(99) < 11) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid          = 1'b1;
    byte_if.byte_value     = b;
    byte_if.message_length = mlen;
    byte_if.first_byte     = first;
    byte_if.last_byte      = last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic put16(input int v);
    hello_q.push_back(v[15:8]);
    hello_q.push_back(v[7:0]);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) hello_q.push_back(8'($urandom));
  endtask

  // build a ClientHello; a negative argument leaves that choice random
  task automatic build_hello(input int n_req, input int sni_req, input int entry_req,
                             input int name_req);
    int n_ext, sni_slot, entry, name_len, ext_at, sni_len_at, span, t;
    bit noisy;
    noisy = (n_req < 0);
    hello_q.delete();
    push_random(SESSION_ID_AT);
    if (!noisy || $urandom_range(15) != 0) hello_q[0] = TLS_HANDSHAKE;
    if (!noisy || $urandom_range(15) != 0) hello_q[1] = TLS_MAJOR;
    if (!noisy || $urandom_range(15) != 0) hello_q[HELLO_TYPE_AT] = TLS_CLIENT_HELLO;
    // session id
    span = (noisy && $urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(8);
    hello_q.push_back(8'(span));
    push_random(span > 40 ? 40 : span);
    // cipher suites
    span = (noisy && $urandom_range(9) == 0) ? $urandom_range(65535) :
           2 * $urandom_range(1, 6);
    put16(span);
    push_random(span > 40 ? 40 : span);
    // compression methods
    span = (noisy && $urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 2);
    hello_q.push_back(8'(span));
    push_random(span > 8 ? 8 : span);
    // extension block, length patched once the body is known
    ext_at = hello_q.size();
    put16(0);
    if (n_req >= 0) n_ext = n_req;
    else n_ext = ($urandom_range(9) == 0) ? $urandom_range(11, 13) : $urandom_range(4);
    sni_slot = (sni_req >= 0) ? sni_req : $urandom_range(n_ext);
    for (int i = 0; i < n_ext; i++) begin
      if (i == sni_slot || (noisy && i > sni_slot && $urandom_range(7) == 0)) begin
        if (entry_req >= 0) entry = entry_req;
        else entry = ($urandom_range(5) == 0) ? $urandom_range(1, 255) : 0;
        if (name_req >= 0) name_len = name_req;
        else begin
          t = $urandom_range(9);
          name_len = (t == 0) ? 0 : (t == 1) ? $urandom_range(60, 70) : $urandom_range(1, 20);
        end
        put16(0);
        sni_len_at = hello_q.size();
        put16(5 + name_len);
        put16(3 + name_len);
        hello_q.push_back(8'(entry));
        put16(name_len);
        push_random(name_len);
        // bad extension length makes a skip point backward
        if (noisy && $urandom_range(7) == 0) begin
          hello_q[sni_len_at]     = 8'h00;
          hello_q[sni_len_at + 1] = 8'($urandom_range(6));
        end
      end else begin
        t = $urandom_range(4);
        put16($urandom_range(1, 65535));
        put16(t);
        push_random(t);
      end
    end
    span = hello_q.size() - ext_at - 2;
    if (noisy) begin
      case ($urandom_range(11))
        0: span = $urandom_range(65535);
        1: span = (span > 12) ? span - $urandom_range(1, 12) : 0;
        default: ;
      endcase
    end
    hello_q[ext_at]     = span[15:8];
    hello_q[ext_at + 1] = span[7:0];
    // occasional corrupted byte past the fixed header
    if (noisy && $urandom_range(7) == 0)
      hello_q[$urandom_range(SESSION_ID_AT, hello_q.size() - 1)] = 8'($urandom);
  endtask

  task automatic deliver(input int mlen, input int last_at);
    for (int i = 0; i < hello_q.size(); i++) begin
      offer(hello_q[i], 16'(mlen), i == 0, i == last_at);
      byte_total++;
    end
  endtask

  // result side: random stalls plus one long hold-off once armed
  initial begin : result_sink
    int hold_left;
    sni_result_t got;
    hold_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        got.name_char    = result_if.name_char;
        got.char_valid   = result_if.char_valid;
        got.name_last    = result_if.name_last;
        got.message_done = result_if.message_done;
        got.status       = result_if.status;
        sb.check_result(got);
      end
      @(negedge clk);
      if (hold_armed && result_if.valid) begin
        hold_left  = 80;
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else begin
        result_if.ready = quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  // stimulus
  initial begin : byte_source
    int sends, mode, len, last_at, mlen;
    rst                    = 1'b1;
    byte_if.valid          = 1'b0;
    byte_if.byte_value     = '0;
    byte_if.message_length = '0;
    byte_if.first_byte     = 1'b0;
    byte_if.last_byte      = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // stray byte while idle: ignored, no status
    offer(8'h00, 16'd0, 1'b0, 1'b1);
    // empty send
    offer(8'hff, 16'd0, 1'b1, 1'b1);
    // send ends before the hello type byte
    offer(TLS_HANDSHAKE, 16'hffff, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'hffff, 1'b0, 1'b0);
    offer(8'hff, 16'hffff, 1'b0, 1'b1);
    // wrong record type, decided before the end
    offer(8'h17, 16'd100, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'd100, 1'b0, 1'b0);
    offer(8'h55, 16'd100, 1'b0, 1'b1);
    // new send mid-stream, then too short
    offer(TLS_HANDSHAKE, 16'd47, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'd47, 1'b0, 1'b0);
    offer(TLS_HANDSHAKE, 16'd46, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'd46, 1'b0, 1'b1);
    // ends after the hello type byte inside the header
    offer(TLS_HANDSHAKE, 16'd300, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'd300, 1'b0, 1'b0);
    offer(8'h03, 16'd300, 1'b0, 1'b0);
    offer(8'h00, 16'd300, 1'b0, 1'b0);
    offer(8'h10, 16'd300, 1'b0, 1'b0);
    offer(TLS_CLIENT_HELLO, 16'd300, 1'b0, 1'b0);
    offer(8'h00, 16'd300, 1'b0, 1'b1);
    // wrong handshake type
    offer(TLS_HANDSHAKE, 16'd80, 1'b1, 1'b0);
    offer(TLS_MAJOR, 16'd80, 1'b0, 1'b0);
    offer(8'h03, 16'd80, 1'b0, 1'b0);
    offer(8'h00, 16'd80, 1'b0, 1'b0);
    offer(8'h40, 16'd80, 1'b0, 1'b0);
    offer(8'h02, 16'd80, 1'b0, 1'b1);

    sends = 0;
    while (byte_total < 500 || sends < 8) begin
      case (sends)
        0: build_hello(1, 0, 0, 0);      // empty host name
        1: build_hello(2, 1, 0, 70);     // name past the buffer, truncated
        2: build_hello(2, 0, 1, 5);      // non-host_name entry gets skipped
        3: build_hello(12, 20, 0, 4);    // walk runs out of extension slots
        4: build_hello(0, 0, 0, 0);      // no extensions at all
        default: build_hello(-1, -1, -1, -1);
      endcase
      if (sends == 5) hold_armed = 1'b1;
      if (sends == 6) begin
        byte_if.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
      end
      quiet = (sends == 7);

      mode    = (sends < 5) ? 0 : $urandom_range(99);
      len     = hello_q.size();
      mlen    = len;
      last_at = len - 1;
      if (mode >= 58 && mode < 68) begin
        // ends early
        last_at = $urandom_range(len - 1);
      end else if (mode >= 68 && mode < 76) begin
        // bogus length field
        mlen = $urandom_range(65535);
      end else if (mode >= 76 && mode < 84) begin
        // padded with random bytes after the hello
        push_random($urandom_range(1, 200));
        mlen    = hello_q.size();
        last_at = mlen - 1;
      end else if (mode >= 84 && mode < 90) begin
        // too short to be a hello
        len = $urandom_range(1, 6);
        while (hello_q.size() > len) void'(hello_q.pop_back());
        mlen    = $urandom_range(MIN_HELLO - 1);
        last_at = len - 1;
      end else if (mode >= 90 && mode < 95) begin
        // abandoned, next send starts over it
        len = $urandom_range(1, len);
        while (hello_q.size() > len) void'(hello_q.pop_back());
        last_at = -1;
      end
      deliver(mlen, last_at);
      if (mode >= 95) begin
        // stray bytes between sends
        repeat ($urandom_range(1, 4))
          offer(8'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(1)));
      end
      sends++;
    end
    quiet = 1'b0;

    byte_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tls_client_hello_sni_extract_top test passed");
    end else begin
      $display("tls_client_hello_sni_extract_top test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("tls_client_hello_sni_extract_top test failed");
    $finish;
  end

endmodule
